// ----- rtl/integer_to_ascii_radix_assert.svh -----
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ITOA_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ITOA_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/itoar_pkg.sv -----
package itoar_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int NDEC        = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NHEX        = (VALUE_WIDTH + 3) / 4;
  localparam int BCD_WIDTH   = 4 * NDEC;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_W       = $clog2(BCD_WIDTH + 1);

  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [7:0] ASCII_MINUS = 8'h2d;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             base_select;
  } in_word_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       is_last;
    logic [5:0] text_length;
  } out_word_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h61;
      4'd11:   c = 8'h62;
      4'd12:   c = 8'h63;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/integer_to_ascii_radix.sv -----
// Sequence: binary and hex skip up to VALUE_WIDTH-1 (binary) or NHEX-1 (hex) leading zero
// digits, then emit one character per cycle while the output is not stalled; decimal first
// runs the bit-serial double dabble, then skips and emits in the same way.
// Throughput: one word at a time; the next word is taken once the last character of the
// previous one is in the output register. A word with base code 3 is taken and dropped.
// Reset clears the sequencer and the output valid; data registers are not reset.
module integer_to_ascii_radix import itoar_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_word_t  req_word,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_word_t rsp_word
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SKIP, S_EMIT} state_t;

  state_t                 state;
  logic [BCD_WIDTH-1:0]   dreg;
  logic [DIG_W-1:0]       ndig;
  logic [1:0]             base;
  logic                   neg;
  logic                   neg_pend;
  logic [5:0]             text_len;

  logic                   sign;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   dab_start;
  logic                   dab_done;
  logic [BCD_WIDTH-1:0]   bcd;
  logic [3:0]             cur_digit;
  logic                   top_zero;
  logic                   skip_more;
  logic                   out_free;
  logic                   emit_fire;
  logic [DIG_W:0]         len_full;

  assign req_stall = (state != S_IDLE);
  assign sign      = req_word.value[VALUE_WIDTH-1];
  assign mag       = sign ? VALUE_WIDTH'(~req_word.value + VALUE_WIDTH'(1)) : req_word.value;
  assign dab_start = (state == S_IDLE) && req_valid && (req_word.base_select == BASE_DEC);
  assign cur_digit = (base == BASE_BIN) ? {3'b000, dreg[BCD_WIDTH-1]} : dreg[BCD_WIDTH-1 -: 4];
  assign top_zero  = (cur_digit == 4'd0);
  assign skip_more = top_zero && (ndig != DIG_W'(1));
  assign out_free  = !rsp_valid || !rsp_stall;
  assign emit_fire = (state == S_EMIT) && out_free;
  assign len_full  = {1'b0, ndig} + {{DIG_W{1'b0}}, neg};

  itoar_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .mag   (mag),
    .done  (dab_done),
    .bcd   (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      neg_pend  <= 1'b0;
    end else begin
      rsp_valid <= emit_fire || (rsp_valid && rsp_stall);
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            base <= req_word.base_select;
            neg  <= (req_word.base_select == BASE_DEC) && sign;
            case (req_word.base_select)
              BASE_BIN: begin
                dreg  <= BCD_WIDTH'(req_word.value) << (BCD_WIDTH - VALUE_WIDTH);
                ndig  <= DIG_W'(VALUE_WIDTH);
                state <= S_SKIP;
              end
              BASE_HEX: begin
                dreg  <= BCD_WIDTH'(req_word.value) << (BCD_WIDTH - 4 * NHEX);
                ndig  <= DIG_W'(NHEX);
                state <= S_SKIP;
              end
              BASE_DEC: begin
                state <= S_CONV;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_CONV: begin
          if (dab_done) begin
            dreg  <= bcd;
            ndig  <= DIG_W'(NDEC);
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_more) begin
            dreg <= (base == BASE_BIN) ? (dreg << 1) : (dreg << 4);
            ndig <= ndig - DIG_W'(1);
          end else begin
            neg_pend <= neg;
            text_len <= 6'(len_full);
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_word.text_length <= text_len;
            if (neg_pend) begin
              rsp_word.ascii_char <= ASCII_MINUS;
              rsp_word.is_last    <= 1'b0;
              neg_pend            <= 1'b0;
            end else begin
              rsp_word.ascii_char <= digit_char(cur_digit);
              rsp_word.is_last    <= (ndig == DIG_W'(1));
              dreg <= (base == BASE_BIN) ? (dreg << 1) : (dreg << 4);
              ndig <= ndig - DIG_W'(1);
              if (ndig == DIG_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "integer_to_ascii_radix_assert.svh"

  `ITOA_ASSERT_IMP(a_done_in_conv, dab_done, state == S_CONV, "converter done outside conversion")
  `ITOA_ASSERT_IMP(a_more_to_emit, rsp_valid && !rsp_word.is_last, state == S_EMIT, "left emit early")
  `ITOA_ASSERT_IMP(a_digits_left, state == S_EMIT || state == S_SKIP, ndig != '0, "digit count ran out")
  `ITOA_ASSERT_NEXT(a_minus_first, state == S_SKIP && !skip_more && neg, neg_pend, "minus not pending")

endmodule

// ----- rtl/itoar_dabble.sv -----
module itoar_dabble import itoar_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] mag,
  output logic                   done,
  output logic [BCD_WIDTH-1:0]   bcd
);

  logic [VALUE_WIDTH-1:0] mreg;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic [BCD_WIDTH-1:0]   adj;

  // add three to every nibble of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = 4'(bcd[4*i +: 4] + 4'd3);
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mreg <= mag;
        bcd  <= '0;
        cnt  <= CNT_W'(VALUE_WIDTH);
        busy <= 1'b1;
      end else if (busy) begin
        bcd  <= {adj[BCD_WIDTH-2:0], mreg[VALUE_WIDTH-1]};
        mreg <= mreg << 1;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
